// ===== src/ftsch_pkg.sv =====
// Shared constants, register codes and sequencer states of the frame tick scheduler.
package ftsch_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int FIELD_BITS    = 48;
    localparam int START_BITS    = 49;
    localparam int CFG_BITS      = 20;
    localparam int IN_DATA_BITS  = 3 * FIELD_BITS;
    localparam int OUT_DATA_BITS = 104;
    localparam int IN_USER_BITS  = 2;
    localparam int OUT_USER_BITS = 1;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [CFG_BITS-1:0] INTERVAL_RST = CFG_BITS'(16667);
    localparam logic [CFG_BITS-1:0] MIN_TICK_RST = CFG_BITS'(1000);
    localparam logic [CFG_BITS-1:0] MAX_TICK_RST = CFG_BITS'(3000);

    typedef enum logic [1:0] {
        REG_INTERVAL = 2'd0,
        REG_MIN_TICK = 2'd1,
        REG_MAX_TICK = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LATE,
        ST_MOD_NOW,
        ST_MOD_LAST,
        ST_CLOSE,
        ST_LEAD,
        ST_MOD_LEAD,
        ST_SAT,
        ST_DONE
    } state_t;

endpackage

// ===== src/frame_tick_scheduler_top.sv =====
// Frame tick scheduler top level: APB registers, sequencer and time datapath.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+-------------------------------------------
//  s_       | in        | s_tvalid/tready  | tdata: now, last interval, last target
//           |           |                  | tuser: have last interval, have last target
//  m_       | out       | m_tvalid/tready  | tdata: tick start (signed), target
//           |           |                  | tuser: target valid
//  apb      | in        | psel/penable     | interval, min tick, max tick registers
//
// Between accept and result one item may take up to three remainder runs on the shared
// two-bit-per-cycle divider (W = max(TIME_BITS,48)+2). Without a last interval time the
// sequencer goes straight from idle to the done state.
// Reset (aresetn low at a clock edge) empties the sequencer and output and loads the
// register defaults. s_tready is high only while the sequencer idles; a stalled result
// sits in the output register while the next item is taken in and worked on.
module frame_tick_scheduler_top #(
    parameter int TIME_BITS = ftsch_pkg::TIME_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ftsch_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [ftsch_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [ftsch_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                pready,
    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [47:0] now_us, [95:48] last_interval_us, [143:96] last_target_us
    input  logic [ftsch_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // [0] have_last_interval, [1] have_last_target
    input  logic [ftsch_pkg::IN_USER_BITS-1:0]  s_tuser,
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [48:0] tick_start_us, [96:49] target_us, [103:97] zero
    output logic [ftsch_pkg::OUT_DATA_BITS-1:0] m_tdata,
    // [0] target_valid
    output logic [ftsch_pkg::OUT_USER_BITS-1:0] m_tuser
);
    import ftsch_pkg::*;

    // Working width: saturated times plus one interval and one lead still fit.
    localparam int W  = ((TIME_BITS > FIELD_BITS) ? TIME_BITS : FIELD_BITS) + 2;
    localparam int DW = W + (W % 2);
    localparam logic [W-1:0] TMAX = {{(W - TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};

    // Saturate a time field to the time range.
    function automatic logic [W-1:0] clamp_time(input logic [FIELD_BITS-1:0] v);
        logic [W-1:0] e;
        e = W'(v);
        return (e > TMAX) ? TMAX : e;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_BITS-1:0] ivl_cfg_reg;
    logic [CFG_BITS-1:0] min_cfg_reg;
    logic [CFG_BITS-1:0] max_cfg_reg;
    logic                cfg_wr;
    reg_idx_t            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ivl_cfg_reg <= INTERVAL_RST;
            min_cfg_reg <= MIN_TICK_RST;
            max_cfg_reg <= MAX_TICK_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_INTERVAL: ivl_cfg_reg <= pwdata[CFG_BITS-1:0];
                REG_MIN_TICK: min_cfg_reg <= pwdata[CFG_BITS-1:0];
                REG_MAX_TICK: max_cfg_reg <= pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_INTERVAL: prdata = APB_DATA_BITS'(ivl_cfg_reg);
            REG_MIN_TICK: prdata = APB_DATA_BITS'(min_cfg_reg);
            REG_MAX_TICK: prdata = APB_DATA_BITS'(max_cfg_reg);
            default:      prdata = '0;
        endcase
    end

    // Effective settings: zero interval acts as one, minimum clamped to maximum.
    logic [CFG_BITS-1:0] ivl;
    logic [CFG_BITS-1:0] mn;
    logic [W-1:0]        ivl_w;
    logic [W-1:0]        mn_w;
    logic [W-1:0]        mx_w;

    assign ivl   = (ivl_cfg_reg == '0) ? CFG_BITS'(1) : ivl_cfg_reg;
    assign mn    = (min_cfg_reg > max_cfg_reg) ? max_cfg_reg : min_cfg_reg;
    assign ivl_w = W'(ivl);
    assign mn_w  = W'(mn);
    assign mx_w  = W'(max_cfg_reg);

    // ------------------------------------------------------------------
    // Sequencer and datapath
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;

    logic [W-1:0] now_reg;
    logic [W-1:0] last_i_reg;
    logic [W-1:0] last_t_reg;
    logic [W-1:0] thr_reg;
    logic [W-1:0] target_reg;
    logic         have_li_reg;
    logic         have_lt_reg;

    logic [W-1:0] in_now;
    logic [W-1:0] in_last_i;
    logic [W-1:0] in_last_t;
    logic         in_acc;

    logic         late_hit;
    logic         lead_hit;
    logic [W-1:0] lead_gap;
    logic [W-1:0] start_w;
    logic         out_free;
    logic         out_load;

    logic                div_start;
    logic [DW-1:0]       div_dvd;
    logic                rem_done;
    logic [CFG_BITS-1:0] rem;

    logic [START_BITS-1:0] out_start_reg;
    logic [FIELD_BITS-1:0] out_target_reg;
    logic                  out_tvalid_reg;
    logic                  m_valid_reg;

    assign in_now    = clamp_time(s_tdata[FIELD_BITS-1:0]);
    assign in_last_i = clamp_time(s_tdata[2*FIELD_BITS-1:FIELD_BITS]);
    assign in_last_t = clamp_time(s_tdata[3*FIELD_BITS-1:2*FIELD_BITS]);
    assign in_acc    = s_tvalid && s_tready;

    assign late_hit = target_reg < now_reg;
    assign lead_hit = target_reg < thr_reg;
    assign lead_gap = thr_reg - target_reg;
    assign start_w  = target_reg - mx_w;
    assign out_free = !m_valid_reg || m_tready;

    ftsch_rem_unit #(
        .DVD_BITS (DW)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (ivl),
        .done     (rem_done),
        .rem      (rem)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = s_tuser[0] ? ST_LATE : ST_DONE;
                end
            end
            ST_LATE:     state_next = late_hit ? ST_MOD_NOW : ST_CLOSE;
            ST_MOD_NOW:  if (rem_done) state_next = ST_MOD_LAST;
            ST_MOD_LAST: if (rem_done) state_next = ST_CLOSE;
            ST_CLOSE:    state_next = ST_LEAD;
            ST_LEAD:     state_next = lead_hit ? ST_MOD_LEAD : ST_SAT;
            ST_MOD_LEAD: if (rem_done) state_next = ST_SAT;
            ST_SAT:      state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, divider launches, result load
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        div_dvd   = DW'(now_reg);
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_LATE: begin
                div_start = late_hit;
                div_dvd   = DW'(now_reg);
            end
            ST_MOD_NOW: begin
                div_start = rem_done;
                div_dvd   = DW'(last_i_reg);
            end
            ST_LEAD: begin
                div_start = lead_hit;
                div_dvd   = DW'(lead_gap);
            end
            ST_DONE: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Time datapath: each step is made of wide adds, subtracts and compares
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            now_reg     <= in_now;
            last_i_reg  <= in_last_i;
            last_t_reg  <= in_last_t;
            have_li_reg <= s_tuser[0];
            have_lt_reg <= s_tuser[1];
            thr_reg     <= in_now + mn_w;
            target_reg  <= in_last_i + ivl_w;
        end else begin
            case (state_reg)
                // late: drop to the start of the current interval ...
                ST_MOD_NOW: if (rem_done) target_reg <= now_reg - W'(rem);
                // ... then add back the phase of the last interval
                ST_MOD_LAST: if (rem_done) target_reg <= target_reg + W'(rem);
                ST_CLOSE: begin
                    if (have_lt_reg && (target_reg < last_t_reg + mn_w)) begin
                        target_reg <= last_t_reg + ivl_w;
                    end
                end
                // advance to the first interval step at or past the threshold
                ST_MOD_LEAD: begin
                    if (rem_done) begin
                        target_reg <= thr_reg + ((rem == '0) ? '0 : W'(ivl - rem));
                    end
                end
                ST_SAT: if (target_reg > TMAX) target_reg <= TMAX;
                default: ;
            endcase
        end
    end

    // Output register: hold the result until taken
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_start_reg  <= have_li_reg ? start_w[START_BITS-1:0]
                                          : now_reg[START_BITS-1:0];
            out_target_reg <= have_li_reg ? target_reg[FIELD_BITS-1:0] : '0;
            out_tvalid_reg <= have_li_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_DATA_BITS - START_BITS - FIELD_BITS)'(0),
                       out_target_reg, out_start_reg};
    assign m_tuser  = out_tvalid_reg;

`ifndef SYNTHESIS
    a_rem_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_done |-> (state_reg == ST_MOD_NOW || state_reg == ST_MOD_LAST ||
                      state_reg == ST_MOD_LEAD))
        else $error("remainder finished outside a wait state");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready right after accepting an item");

    a_lead_reached: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SAT && $past(state_reg) == ST_MOD_LEAD) |->
            (target_reg >= thr_reg))
        else $error("interval stepping left target short of threshold");

    a_no_target_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[96:49] == '0))
        else $error("invalid target not zero");
`endif

endmodule

// ===== src/ftsch_rem_unit.sv =====
// Shared remainder unit: restoring division, two dividend bits per cycle.
module ftsch_rem_unit #(
    parameter int DVD_BITS = 50
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [DVD_BITS-1:0]           dividend,
    input  logic [ftsch_pkg::CFG_BITS-1:0] divisor,
    output logic                          done,
    output logic [ftsch_pkg::CFG_BITS-1:0] rem
);
    import ftsch_pkg::*;

    localparam int STEPS = DVD_BITS / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [DVD_BITS-1:0] dvd_reg;
    logic [CFG_BITS-1:0] rem_reg;
    logic [CFG_BITS-1:0] rem_next;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [CFG_BITS:0]   t1;
    logic [CFG_BITS:0]   t2;

    // Shift in two bits, subtract the divisor after each when it fits.
    always_comb begin
        t1 = {rem_reg, dvd_reg[DVD_BITS-1]};
        if (t1 >= {1'b0, divisor}) begin
            t1 = t1 - {1'b0, divisor};
        end
        t2 = {t1[CFG_BITS-1:0], dvd_reg[DVD_BITS-2]};
        if (t2 >= {1'b0, divisor}) begin
            t2 = t2 - {1'b0, divisor};
        end
        rem_next = t2[CFG_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << 2;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
